// ----- rtl/escape_time_fractal_iterator_assert.svh -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: assertion macros
// Shorthand for the clocked, reset-gated properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_ASSERT_SVH

// same-cycle implication
`define EFI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape_time_fractal_iterator: property failed");

// next-cycle implication
`define EFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape_time_fractal_iterator: property failed");

`endif

// ----- rtl/efi_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: package
// Widths, limits, register indexes and the per-step evaluation struct.
// ----------------------------------------------------------------------------
`default_nettype none

package efi_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_ITER    = 256;
    localparam int JULIA_LIMIT = 256;
    localparam int COUNT_MAX   = (MAX_ITER > JULIA_LIMIT) ? MAX_ITER : JULIA_LIMIT;

    localparam logic [COUNT_W-1:0] MAX_ITER_CNT    = COUNT_W'(MAX_ITER);
    localparam logic [COUNT_W-1:0] JULIA_LIMIT_CNT = COUNT_W'(JULIA_LIMIT);
    localparam logic [COUNT_W-1:0] COUNT_MAX_CNT   = COUNT_W'(COUNT_MAX);

    // 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_MAG = 64'h0400_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JC_RE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JC_IM   = 2'd2;

    localparam logic MODE_MANDEL = 1'b0;
    localparam logic MODE_JULIA  = 1'b1;

    typedef struct packed {
        logic                     finish;
        logic signed [DATA_W-1:0] zr;
        logic signed [DATA_W-1:0] zi;
    } efi_eval_t;

endpackage

`default_nettype wire

// ----- rtl/efi_if.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: channel interfaces
// Point word in, iteration-count word out, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface efi_point_if
    import efi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] point_re;
    logic signed [DATA_W-1:0] point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface efi_count_if
    import efi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/efi_mul.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: shared multiplier
// Signed 32 x 32 multiply, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module efi_mul
    import efi_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [DATA_W-1:0] a,
    input  wire logic signed [DATA_W-1:0] b,
    output      logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/efi_update.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: step evaluation
// Escape and limit test, next z with floor rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module efi_update
    import efi_pkg::*;
(
    input  wire logic signed [PROD_W-1:0] rr,
    input  wire logic signed [PROD_W-1:0] ii,
    input  wire logic signed [PROD_W-1:0] ri,
    input  wire logic signed [DATA_W-1:0] cr,
    input  wire logic signed [DATA_W-1:0] ci,
    input  wire logic                     julia,
    input  wire logic [COUNT_W-1:0]       count,
    output      efi_eval_t                eval
);

    logic [PROD_W-1:0]        mag;
    logic signed [PROD_W-1:0] cr_ext;
    logic signed [PROD_W-1:0] ci_ext;
    logic signed [PROD_W-1:0] nr_full;
    logic signed [PROD_W-1:0] ni_full;
    logic                     nr_fits;
    logic                     ni_fits;
    logic                     escape;
    logic                     limit_hit;

    assign mag    = $unsigned(rr) + $unsigned(ii);
    assign cr_ext = {{(PROD_W-DATA_W){cr[DATA_W-1]}}, cr};
    assign ci_ext = {{(PROD_W-DATA_W){ci[DATA_W-1]}}, ci};

    // zr' = (rr - ii + cr*2^28) >> 28, zi' = (ri + ci*2^27) >> 27
    assign nr_full = rr - ii + (cr_ext <<< FRAC_BITS);
    assign ni_full = ri + (ci_ext <<< (FRAC_BITS - 1));

    assign nr_fits = (&nr_full[PROD_W-1:FRAC_BITS+DATA_W-1])
                   | ~(|nr_full[PROD_W-1:FRAC_BITS+DATA_W-1]);
    assign ni_fits = (&ni_full[PROD_W-1:FRAC_BITS+DATA_W-2])
                   | ~(|ni_full[PROD_W-1:FRAC_BITS+DATA_W-2]);

    assign escape    = julia ? (mag >= ESCAPE_MAG) : (mag > ESCAPE_MAG);
    assign limit_hit = (count == (julia ? JULIA_LIMIT_CNT : MAX_ITER_CNT));

    always_comb
    begin
        eval.finish = escape | limit_hit;
        if (nr_fits)
            eval.zr = nr_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
        else if (nr_full[PROD_W-1])
            eval.zr = {1'b1, {(DATA_W-1){1'b0}}};
        else
            eval.zr = {1'b0, {(DATA_W-1){1'b1}}};
        if (ni_fits)
            eval.zi = ni_full[FRAC_BITS+DATA_W-2:FRAC_BITS-1];
        else if (ni_full[PROD_W-1])
            eval.zi = {1'b1, {(DATA_W-1){1'b0}}};
        else
            eval.zi = {1'b0, {(DATA_W-1){1'b1}}};
    end

endmodule

`default_nettype wire

// ----- rtl/escape_time_fractal_iterator.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator
// Mandelbrot / Julia escape-time count for one Q4.28 complex point per word.
// ----------------------------------------------------------------------------
// One point word is taken at a time; the input is not ready until its count
// is handed to the output register. Each iteration of z <- z^2 + c runs
// through the states S_MRR, S_MII, S_MRI and S_EVAL: the single 32 x 32
// multiplier forms zr^2, zi^2 and zr*zi in turn, then S_EVAL tests |z|^2
// against 4.0 and updates z. A point stops on escape or at the iteration
// limit (256). The output register holds a finished count while the next
// point is already being iterated.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_iterator
    import efi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    efi_point_if.sink                 point,
    efi_count_if.source               result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MRR  = 3'd1;
    localparam logic [2:0] S_MII  = 3'd2;
    localparam logic [2:0] S_MRI  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]               state_reg,     state_next;
    logic                     mode_reg,      mode_next;
    logic signed [DATA_W-1:0] jc_re_reg,     jc_re_next;
    logic signed [DATA_W-1:0] jc_im_reg,     jc_im_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                     julia_reg,     julia_next;
    logic signed [DATA_W-1:0] zr_reg,        zr_next;
    logic signed [DATA_W-1:0] zi_reg,        zi_next;
    logic signed [DATA_W-1:0] cr_reg,        cr_next;
    logic signed [DATA_W-1:0] ci_reg,        ci_next;
    logic signed [PROD_W-1:0] rr_reg,        rr_next;
    logic signed [PROD_W-1:0] ii_reg,        ii_next;
    logic [COUNT_W-1:0]       count_reg,     count_next;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    efi_eval_t                eval;

    always_comb
    begin
        case (state_reg)
            S_MRR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_MII:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    efi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // prod holds zr*zi during S_EVAL
    efi_update u_update (
        .rr    (rr_reg),
        .ii    (ii_reg),
        .ri    (prod),
        .cr    (cr_reg),
        .ci    (ci_reg),
        .julia (julia_reg),
        .count (count_reg),
        .eval  (eval)
    );

    always_comb
    begin
        mode_next  = mode_reg;
        jc_re_next = jc_re_reg;
        jc_im_next = jc_im_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_next  = cfg_data[0];
                CFG_JC_RE: jc_re_next = cfg_data;
                CFG_JC_IM: jc_im_next = cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        julia_next     = julia_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        count_next     = count_reg;

        if (result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (point.valid)
                begin
                    julia_next = (mode_reg == MODE_JULIA);
                    count_next = '0;
                    if (mode_reg == MODE_JULIA)
                    begin
                        zr_next = point.point_re;
                        zi_next = point.point_im;
                        cr_next = jc_re_reg;
                        ci_next = jc_im_reg;
                    end
                    else
                    begin
                        zr_next = '0;
                        zi_next = '0;
                        cr_next = point.point_re;
                        ci_next = point.point_im;
                    end
                    state_next = S_MRR;
                end
            end
            S_MRR:
            begin
                state_next = S_MII;
            end
            S_MII:
            begin
                rr_next    = prod;
                state_next = S_MRI;
            end
            S_MRI:
            begin
                ii_next    = prod;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (eval.finish)
                    state_next = S_DONE;
                else
                begin
                    zr_next    = eval.zr;
                    zi_next    = eval.zi;
                    count_next = count_reg + 1'b1;
                    state_next = S_MRR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_MANDEL;
            jc_re_reg     <= '0;
            jc_im_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            jc_re_reg     <= jc_re_next;
            jc_im_reg     <= jc_im_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
        julia_reg     <= julia_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        rr_reg        <= rr_next;
        ii_reg        <= ii_next;
        count_reg     <= count_next;
    end

    assign point.ready            = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.iteration_count = out_count_reg;

endmodule

`default_nettype wire

// ----- rtl/efi_checker.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator: port checker
// Port-level properties of the iterator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_time_fractal_iterator_assert.svh"

module efi_checker
    import efi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [COUNT_W-1:0] out_count
);

    // a stalled word holds
    `EFI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_count))
    // one point in flight
    `EFI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a count needs at least one evaluation pass
    `EFI_ASSERT_NEXT(a_no_instant_word, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    `EFI_ASSERT_IMPLY(a_count_bound, clk, rst_n, out_valid, out_count <= COUNT_MAX_CNT)

endmodule

bind escape_time_fractal_iterator efi_checker u_efi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_count (result.iteration_count)
);

`default_nettype wire
